// ===== hw/rtl/ptns_pkg.sv =====
// Package: shared types and constants of the priority tune note sequencer.
`default_nettype none

package ptns_pkg;

    localparam int TUNE_DEPTH_DEFAULT = 256;

    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int VOLUME_W   = 2;
    localparam int ELAPSED_W  = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [HALF_W-1:0]    TONE_CLOCK    = 16'd50000;
    localparam logic [HALF_W-1:0]    STOP_COMPARE  = 16'd5001;
    localparam logic [HALF_W-1:0]    STOP_PERIOD   = 16'd5000;
    localparam logic [HALF_W-1:0]    FIXED_COMPARE = 16'd5000;
    localparam logic [HALF_W-1:0]    PERIOD_RESET  = 16'd999;
    localparam logic [HALF_W-1:0]    COMPARE_RESET = 16'd500;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 18'h3FFFF;
    localparam logic [VOLUME_W-1:0]  VOLUME_RESET  = 2'd3;
    localparam logic [HALF_W-1:0]    PAUSE_RESET   = 16'd1;

    localparam logic [VOLUME_W-1:0] VOL_FIXED   = 2'd0;
    localparam logic [VOLUME_W-1:0] VOL_EIGHTH  = 2'd1;
    localparam logic [VOLUME_W-1:0] VOL_QUARTER = 2'd2;
    localparam logic [VOLUME_W-1:0] VOL_HALF    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_TICK = 2'd2
    } cmd_code_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] word_address;
        logic [WORD_W-1:0] note_word;
        logic [BYTE_W-1:0] tune_start;
        logic [BYTE_W-1:0] request_priority;
    } in_item_t;

    typedef struct packed {
        logic              timer_enable;
        logic [HALF_W-1:0] period;
        logic [HALF_W-1:0] compare;
        logic              counter_restart;
        logic              pin_forced_low;
        logic              note_active;
        logic [BYTE_W-1:0] current_priority;
        logic [BYTE_W-1:0] note_index;
    } out_item_t;

    typedef struct packed {
        logic latch_in;
        logic play_take;
        logic tick_count;
        logic stop;
        logic addr_fetch;
        logic addr_load;
        logic reduce_step;
        logic mem_write;
        logic mem_read;
        logic apply_note;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_code_t command;
        logic      prio_ok;
        logic      expire;
        logic      addr_over;
        logic      tone_normal;
        logic      div_done;
        logic      out_busy;
    } ctl_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptns_if.sv =====
// Interfaces: request, response and configuration channels.
`default_nettype none

interface ptns_req_if;
    logic                               valid;
    logic                               ready;
    logic [ptns_pkg::CMD_W-1:0]         command;
    logic [ptns_pkg::BYTE_W-1:0]        word_address;
    logic [ptns_pkg::WORD_W-1:0]        note_word;
    logic [ptns_pkg::BYTE_W-1:0]        tune_start;
    logic [ptns_pkg::BYTE_W-1:0]        request_priority;

    modport source (output valid, command, word_address, note_word, tune_start,
                    request_priority, input ready);
    modport sink   (input valid, command, word_address, note_word, tune_start,
                    request_priority, output ready);
endinterface

interface ptns_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               timer_enable;
    logic [ptns_pkg::HALF_W-1:0]        period;
    logic [ptns_pkg::HALF_W-1:0]        compare;
    logic                               counter_restart;
    logic                               pin_forced_low;
    logic                               note_active;
    logic [ptns_pkg::BYTE_W-1:0]        current_priority;
    logic [ptns_pkg::BYTE_W-1:0]        note_index;

    modport source (output valid, timer_enable, period, compare, counter_restart,
                    pin_forced_low, note_active, current_priority, note_index,
                    input ready);
    modport sink   (input valid, timer_enable, period, compare, counter_restart,
                    pin_forced_low, note_active, current_priority, note_index,
                    output ready);
endinterface

interface ptns_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ptns_pkg::CFG_IDX_W-1:0]     index;
    logic [ptns_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ptns_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module ptns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ptns_ctrl.sv =====
// Controller: sequences load, play and tick transactions over the datapath.
`default_nettype none

module ptns_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ptns_pkg::ctl_status_t status,
    output ptns_pkg::ctl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_FETCH_ADDR,
        ST_REDUCE,
        ST_WRITE,
        ST_READ,
        ST_APPLY,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.command)
                    ptns_pkg::CMD_LOAD:
                    begin
                        cmd.addr_load = 1'b1;
                        state_next    = ST_REDUCE;
                    end
                    ptns_pkg::CMD_PLAY:
                    begin
                        if (status.prio_ok)
                        begin
                            cmd.play_take = 1'b1;
                            state_next    = ST_FETCH_ADDR;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    ptns_pkg::CMD_TICK:
                    begin
                        cmd.tick_count = 1'b1;
                        state_next     = ST_CHECK;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (status.expire)
                begin
                    cmd.stop   = 1'b1;
                    state_next = ST_FETCH_ADDR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FETCH_ADDR:
            begin
                cmd.addr_fetch = 1'b1;
                state_next     = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (status.addr_over)
                begin
                    cmd.reduce_step = 1'b1;
                end
                else if (status.command == ptns_pkg::CMD_LOAD)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply_note = 1'b1;
                if (status.tone_normal)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ptns_datapath.sv =====
// Datapath: sequencer state, tune memory, period divider and result register.
`default_nettype none

module ptns_datapath #(
    parameter int TUNE_DEPTH = ptns_pkg::TUNE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ptns_pkg::in_item_t               in_item,
    input  wire logic                             cfg_we,
    input  wire logic [ptns_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ptns_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire ptns_pkg::ctl_cmd_t               cmd,
    output ptns_pkg::ctl_status_t                 status,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output ptns_pkg::out_item_t                   out_item
);

    localparam int AW     = $clog2(TUNE_DEPTH);
    localparam int ADDR_W = (AW + 1 > ptns_pkg::BYTE_W + 1) ? AW + 1 : ptns_pkg::BYTE_W + 1;
    localparam logic [ADDR_W-1:0] DEPTH_C = ADDR_W'(TUNE_DEPTH);

    localparam int HW = ptns_pkg::HALF_W;
    localparam int BW = ptns_pkg::BYTE_W;
    localparam int EW = ptns_pkg::ELAPSED_W;

    ptns_pkg::in_item_t                  in_reg,      in_next;
    logic [ptns_pkg::VOLUME_W-1:0]       volume_reg,  volume_next;
    logic [HW-1:0]                       pause_reg,   pause_next;
    logic [BW-1:0]                       base_reg,    base_next;
    logic [BW-1:0]                       offset_reg,  offset_next;
    logic [BW-1:0]                       prio_reg,    prio_next;
    logic [HW-1:0]                       len_reg,     len_next;
    logic [EW-1:0]                       elapsed_reg, elapsed_next;
    logic [HW-1:0]                       period_reg,  period_next;
    logic [HW-1:0]                       compare_reg, compare_next;
    logic                                running_reg, running_next;
    logic                                restart_reg, restart_next;
    logic                                stop_reg,    stop_next;
    logic [ADDR_W-1:0]                   addr_reg,    addr_next;
    logic [HW-1:0]                       rem_reg,     rem_next;
    logic [HW-1:0]                       quo_reg,     quo_next;
    logic [ptns_pkg::DIV_CNT_W-1:0]      cnt_reg,     cnt_next;
    logic                                ovalid_reg,  ovalid_next;
    ptns_pkg::out_item_t                 oitem_reg,   oitem_next;

    logic [ptns_pkg::WORD_W-1:0]         rd_data;
    logic [HW-1:0]                       tone;
    logic [HW-1:0]                       word_len;
    logic [HW:0]                         rem_sh;
    logic [HW:0]                         rem_diff;

    ptns_ram #(
        .WIDTH (ptns_pkg::WORD_W),
        .DEPTH (TUNE_DEPTH)
    ) u_tune_ram (
        .clk   (clk),
        .we    (cmd.mem_write),
        .re    (cmd.mem_read),
        .addr  (addr_reg[AW-1:0]),
        .wdata (in_reg.note_word),
        .rdata (rd_data)
    );

    assign tone     = rd_data[ptns_pkg::WORD_W-1:HW];
    assign word_len = rd_data[HW-1:0];
    assign rem_sh   = {rem_reg, quo_reg[HW-1]};
    assign rem_diff = rem_sh - {1'b0, tone};

    always_comb
    begin
        status.command     = ptns_pkg::cmd_code_t'(in_reg.command);
        status.prio_ok     = in_reg.request_priority >= prio_reg;
        status.expire      = (len_reg != '0) && (elapsed_reg > {1'b0, len_reg, 1'b0});
        status.addr_over   = addr_reg >= DEPTH_C;
        status.tone_normal = (tone != '0) && (tone != pause_reg);
        status.div_done    = cnt_reg == '0;
        status.out_busy    = ovalid_reg && !out_ready;
    end

    always_comb
    begin
        in_next      = in_reg;
        volume_next  = volume_reg;
        pause_next   = pause_reg;
        base_next    = base_reg;
        offset_next  = offset_reg;
        prio_next    = prio_reg;
        len_next     = len_reg;
        elapsed_next = elapsed_reg;
        period_next  = period_reg;
        compare_next = compare_reg;
        running_next = running_reg;
        restart_next = restart_reg;
        stop_next    = stop_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        oitem_next   = oitem_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ptns_pkg::CFG_VOLUME: volume_next = cfg_data[ptns_pkg::VOLUME_W-1:0];
                ptns_pkg::CFG_PAUSE:  pause_next  = cfg_data[HW-1:0];
                default:              volume_next = volume_reg;
            endcase
        end

        if (cmd.latch_in)
        begin
            in_next      = in_item;
            restart_next = 1'b0;
            stop_next    = 1'b0;
        end

        if (cmd.play_take)
        begin
            prio_next   = in_reg.request_priority;
            base_next   = in_reg.tune_start;
            offset_next = '0;
        end

        if (cmd.tick_count && (elapsed_reg != ptns_pkg::ELAPSED_MAX))
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end

        if (cmd.addr_load)
        begin
            addr_next = ADDR_W'(in_reg.word_address);
        end
        if (cmd.addr_fetch)
        begin
            addr_next = ADDR_W'(base_reg) + ADDR_W'(offset_reg);
        end
        if (cmd.reduce_step)
        begin
            addr_next = addr_reg - DEPTH_C;
        end

        if (cmd.stop || (cmd.apply_note && (tone == '0)))
        begin
            len_next     = '0;
            compare_next = ptns_pkg::STOP_COMPARE;
            period_next  = ptns_pkg::STOP_PERIOD;
            restart_next = 1'b1;
            running_next = 1'b0;
            stop_next    = 1'b1;
        end

        if (cmd.apply_note)
        begin
            offset_next = offset_reg + 1'b1;
            if (tone != '0)
            begin
                len_next     = word_len;
                elapsed_next = '0;
                if (tone == pause_reg)
                begin
                    compare_next = ptns_pkg::STOP_COMPARE;
                    running_next = 1'b0;
                end
            end
            if (word_len == '0)
            begin
                prio_next = '0;
            end
        end

        if (cmd.div_start)
        begin
            rem_next = '0;
            quo_next = ptns_pkg::TONE_CLOCK;
            cnt_next = ptns_pkg::DIV_CNT_W'(ptns_pkg::DIV_STEPS);
        end

        if (cmd.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= {1'b0, tone})
            begin
                rem_next = rem_diff[HW-1:0];
                quo_next = {quo_reg[HW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[HW-1:0];
                quo_next = {quo_reg[HW-2:0], 1'b0};
            end
        end

        if (cmd.div_finish)
        begin
            period_next  = quo_reg;
            restart_next = 1'b1;
            running_next = 1'b1;
            case (volume_reg)
                ptns_pkg::VOL_FIXED:   compare_next = ptns_pkg::FIXED_COMPARE;
                ptns_pkg::VOL_EIGHTH:  compare_next = quo_reg >> 3;
                ptns_pkg::VOL_QUARTER: compare_next = quo_reg >> 2;
                default:               compare_next = quo_reg >> 1;
            endcase
        end

        if (cmd.out_load)
        begin
            ovalid_next                 = 1'b1;
            oitem_next.timer_enable     = running_reg;
            oitem_next.period           = period_reg;
            oitem_next.compare          = compare_reg;
            oitem_next.counter_restart  = restart_reg;
            oitem_next.pin_forced_low   = stop_reg;
            oitem_next.note_active      = len_reg != '0;
            oitem_next.current_priority = prio_reg;
            oitem_next.note_index       = offset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg      <= '0;
            volume_reg  <= ptns_pkg::VOLUME_RESET;
            pause_reg   <= ptns_pkg::PAUSE_RESET;
            base_reg    <= '0;
            offset_reg  <= '0;
            prio_reg    <= '0;
            len_reg     <= '0;
            elapsed_reg <= '0;
            period_reg  <= ptns_pkg::PERIOD_RESET;
            compare_reg <= ptns_pkg::COMPARE_RESET;
            running_reg <= 1'b0;
            restart_reg <= 1'b0;
            stop_reg    <= 1'b0;
            addr_reg    <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
            oitem_reg   <= '0;
        end
        else
        begin
            in_reg      <= in_next;
            volume_reg  <= volume_next;
            pause_reg   <= pause_next;
            base_reg    <= base_next;
            offset_reg  <= offset_next;
            prio_reg    <= prio_next;
            len_reg     <= len_next;
            elapsed_reg <= elapsed_next;
            period_reg  <= period_next;
            compare_reg <= compare_next;
            running_reg <= running_next;
            restart_reg <= restart_next;
            stop_reg    <= stop_next;
            addr_reg    <= addr_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
            oitem_reg   <= oitem_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_tune_note_sequencer_unit.sv =====
// Top level: priority tune note sequencer, controller plus datapath.
//
// Channels: req takes one command transaction (load tune word, play request or
// millisecond tick); rsp returns exactly one result transaction per request,
// holding the timer settings and the sequencer status after that command.
// cfg writes volume (index 0) and pause tone (index 1), always ready; it must be
// written only while no request is in flight, which the block does not enforce.
// Steps: a load reduces the address below TUNE_DEPTH by repeated subtraction
// (at most one subtract step for TUNE_DEPTH of 256 or more), then writes the
// word; an ignored play or unused code goes to the result; a tick counts, and
// if the note ends it stops the tone and goes on as an accepted play: fetch the
// address, reduce, read and apply the note, and for a sounding note run the
// 16-step restoring divider that computes 50000 / tone.
// One request is processed at a time; req.ready is high while the controller
// is idle, and a new request is accepted while the previous result still
// waits in the output register. If rsp stalls, the next result waits in the
// controller until the output register frees.
// Reset clears the sequencer state, sets period 999, compare 500, volume 3 and
// pause tone 1. The tune memory is not cleared and holds garbage until loaded.
`default_nettype none

module priority_tune_note_sequencer_unit #(
    parameter int TUNE_DEPTH = ptns_pkg::TUNE_DEPTH_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    ptns_req_if.sink   req,
    ptns_rsp_if.source rsp,
    ptns_cfg_if.sink   cfg
);

    ptns_pkg::ctl_cmd_t    cmd;
    ptns_pkg::ctl_status_t status;
    ptns_pkg::in_item_t    in_item;
    ptns_pkg::out_item_t   out_item;
    logic                  in_ready;
    logic                  out_valid;

    always_comb
    begin
        in_item.command          = req.command;
        in_item.word_address     = req.word_address;
        in_item.note_word        = req.note_word;
        in_item.tune_start       = req.tune_start;
        in_item.request_priority = req.request_priority;
    end

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid            = out_valid;
    assign rsp.timer_enable     = out_item.timer_enable;
    assign rsp.period           = out_item.period;
    assign rsp.compare          = out_item.compare;
    assign rsp.counter_restart  = out_item.counter_restart;
    assign rsp.pin_forced_low   = out_item.pin_forced_low;
    assign rsp.note_active      = out_item.note_active;
    assign rsp.current_priority = out_item.current_priority;
    assign rsp.note_index       = out_item.note_index;

    ptns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptns_datapath #(
        .TUNE_DEPTH (TUNE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== verif/priority_tune_note_sequencer_unit_tb.sv =====
// Testbench: tune sequencer driven by directed and random commands, checked by an in-bench predictor.
`timescale 1ns / 1ps

module priority_tune_note_sequencer_unit_tb;
    import ptns_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CHUNK_ITEMS    = 345;
    localparam int STEADY_ITEMS   = 250;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int MEM_WORDS      = TUNE_DEPTH_DEFAULT;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam out_item_t IDLE_AFTER_RESET = '{
        timer_enable: 1'b0, period: PERIOD_RESET, compare: COMPARE_RESET,
        counter_restart: 1'b0, pin_forced_low: 1'b0, note_active: 1'b0,
        current_priority: '0, note_index: '0};

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ptns_req_if req_ch ();
    ptns_rsp_if rsp_ch ();
    ptns_cfg_if cfg_ch ();

    priority_tune_note_sequencer_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [WORD_W-1:0]   tune_mem [MEM_WORDS];
    logic [BYTE_W-1:0]   song_base;
    logic [BYTE_W-1:0]   song_offset;
    logic [BYTE_W-1:0]   song_priority;
    logic [HALF_W-1:0]   note_len;
    int                  note_elapsed;
    logic [HALF_W-1:0]   tone_period;
    logic [HALF_W-1:0]   tone_compare;
    logic                tone_running;
    logic                step_restart;
    logic                step_stop;
    logic [VOLUME_W-1:0] volume_sel;
    logic [HALF_W-1:0]   pause_code;

    out_item_t due_results[$];
    stim_row_t directed[$];
    out_item_t got_want;
    int        fail_count = 0;
    int        sent_count = 0;
    int        cycle_count = 0;
    logic      steady = 1'b0;
    logic      holdoff_go = 1'b0;
    logic      holdoff_active = 1'b0;

    function automatic void halt_tone();
        note_len     = '0;
        tone_compare = STOP_COMPARE;
        tone_period  = STOP_PERIOD;
        step_restart = 1'b1;
        tone_running = 1'b0;
        step_stop    = 1'b1;
    endfunction

    function automatic void fetch_next_note();
        logic [BYTE_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [HALF_W-1:0] len;
        logic [HALF_W-1:0] tone;
        logic [HALF_W-1:0] quot;
        addr = song_base + song_offset;
        word = tune_mem[addr];
        len  = word[HALF_W-1:0];
        tone = word[WORD_W-1:HALF_W];
        song_offset = song_offset + 1'b1;
        if (tone == '0)
        begin
            halt_tone();
        end
        else
        begin
            note_len     = len;
            note_elapsed = 0;
            if (tone == pause_code)
            begin
                tone_compare = STOP_COMPARE;
                tone_running = 1'b0;
            end
            else
            begin
                quot = TONE_CLOCK / tone;
                case (volume_sel)
                    VOL_FIXED:   tone_compare = FIXED_COMPARE;
                    VOL_EIGHTH:  tone_compare = quot >> 3;
                    VOL_QUARTER: tone_compare = quot >> 2;
                    default:     tone_compare = quot >> 1;
                endcase
                tone_period  = quot;
                step_restart = 1'b1;
                tone_running = 1'b1;
            end
        end
        if (len == '0)
            song_priority = '0;
    endfunction

    function automatic out_item_t advance_sequencer(input in_item_t it);
        out_item_t r;
        step_restart = 1'b0;
        step_stop    = 1'b0;
        case (it.command)
            CMD_LOAD:
                tune_mem[it.word_address] = it.note_word;
            CMD_PLAY:
                if (it.request_priority >= song_priority)
                begin
                    song_priority = it.request_priority;
                    song_base     = it.tune_start;
                    song_offset   = '0;
                    fetch_next_note();
                end
            CMD_TICK:
            begin
                if (note_elapsed < int'(ELAPSED_MAX))
                    note_elapsed++;
                if (note_len != '0 && note_elapsed > 2 * int'(note_len))
                begin
                    halt_tone();
                    fetch_next_note();
                end
            end
            default: ;
        endcase
        r.timer_enable     = tone_running;
        r.period           = tone_period;
        r.compare          = tone_compare;
        r.counter_restart  = step_restart;
        r.pin_forced_low   = step_stop;
        r.note_active      = (note_len != '0);
        r.current_priority = song_priority;
        r.note_index       = song_offset;
        return r;
    endfunction

    function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd,
                                           input logic [BYTE_W-1:0] addr,
                                           input logic [WORD_W-1:0] word,
                                           input logic [BYTE_W-1:0] start,
                                           input logic [BYTE_W-1:0] prio);
        return '{command: cmd, word_address: addr, note_word: word, tune_start: start,
                 request_priority: prio};
    endfunction

    function automatic stim_row_t make_row(input in_item_t it, input logic typed = 1'b0,
                                           input out_item_t r = '0);
        return '{item: it, typed: typed, result: r};
    endfunction

    // short notes mostly, so that tunes run to their end within a few ticks
    function automatic logic [WORD_W-1:0] compose_note_word();
        logic [HALF_W-1:0] tone;
        logic [HALF_W-1:0] len;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            tone = '0;
        else if (pick < 25)
            tone = pause_code;
        else if (pick < 30)
            tone = 16'd1;
        else if (pick < 35)
            tone = 16'hFFFF;
        else if (pick < 45)
            tone = HALF_W'($urandom_range(2, 100));
        else
            tone = HALF_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            len = '0;
        else if (pick < 88)
            len = HALF_W'($urandom_range(1, 4));
        else
            len = HALF_W'($urandom_range(5, 40));
        return {tone, len};
    endfunction

    function automatic in_item_t noise_item();
        logic [CMD_W-1:0] cmd;
        if ($urandom_range(0, 99) < 5)
            cmd = CMD_UNUSED;
        else
            cmd = CMD_W'($urandom_range(0, 2));
        return make_item(cmd, BYTE_W'($urandom), $urandom, BYTE_W'($urandom),
                         BYTE_W'($urandom));
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
            fail_count++;
        end
    endfunction

    task automatic offer(input in_item_t it);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.command          <= it.command;
        req_ch.word_address     <= it.word_address;
        req_ch.note_word        <= it.note_word;
        req_ch.tune_start       <= it.tune_start;
        req_ch.request_priority <= it.request_priority;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic issue(input in_item_t it);
        offer(it);
        due_results.push_back(advance_sequencer(it));
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_tuning(input logic [VOLUME_W-1:0] vol, input logic [HALF_W-1:0] pause);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_VOLUME;
        cfg_ch.data  <= CFG_DATA_W'(vol);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        volume_sel = vol;
        cfg_ch.index <= CFG_PAUSE;
        cfg_ch.data  <= pause;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        pause_code = pause;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // load a short tune, start it, then let it run for a few ticks
    task automatic play_episode();
        logic [BYTE_W-1:0] start;
        logic [BYTE_W-1:0] prio;
        int n;
        start = BYTE_W'($urandom);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            issue(make_item(CMD_LOAD, start + BYTE_W'(i), compose_note_word(),
                            BYTE_W'($urandom), BYTE_W'($urandom)));
        if ($urandom_range(0, 99) < 80)
            prio = BYTE_W'($urandom_range(255, int'(song_priority)));
        else
            prio = BYTE_W'($urandom);
        issue(make_item(CMD_PLAY, BYTE_W'($urandom), $urandom, start, prio));
        repeat ($urandom_range(0, 12))
            issue(make_item(CMD_TICK, BYTE_W'($urandom), $urandom, BYTE_W'($urandom),
                            BYTE_W'($urandom)));
    endtask

    task automatic random_chunk(input int items);
        int goal;
        int pick;
        goal = sent_count + items;
        while (sent_count < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                play_episode();
            else if (pick < 75)
                repeat ($urandom_range(1, 10))
                    issue(make_item(CMD_TICK, BYTE_W'($urandom), $urandom,
                                    BYTE_W'($urandom), BYTE_W'($urandom)));
            else
                issue(noise_item());
        end
    endtask

    initial
    begin
        out_item_t predicted;
        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.command          = CMD_LOAD;
        req_ch.word_address     = '0;
        req_ch.note_word        = '0;
        req_ch.tune_start       = '0;
        req_ch.request_priority = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = CFG_VOLUME;
        cfg_ch.data             = '0;
        song_base     = '0;
        song_offset   = '0;
        song_priority = '0;
        note_len      = '0;
        note_elapsed  = 0;
        tone_period   = PERIOD_RESET;
        tone_compare  = COMPARE_RESET;
        tone_running  = 1'b0;
        volume_sel    = VOLUME_RESET;
        pause_code    = PAUSE_RESET;

        // tune at 250..255 wrapping to 0
        directed.push_back(make_row(make_item(CMD_TICK, '0, '0, '0, '0), 1'b1,
                                    IDLE_AFTER_RESET));
        directed.push_back(make_row(make_item(CMD_UNUSED, '1, '1, '1, '1), 1'b1,
                                    IDLE_AFTER_RESET));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd250, {16'd1000, 16'd1}, '0, '0),
                                    1'b1, IDLE_AFTER_RESET));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd251, {16'd1, 16'd1}, '0, '0)));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd252, {16'hFFFF, 16'd2}, '0, '0)));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd253, {16'd0, 16'd5}, '0, '0)));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd254, {16'd440, 16'd0}, '0, '0)));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd255, '1, '0, '0)));
        directed.push_back(make_row(make_item(CMD_LOAD, 8'd0, {16'd2, 16'd0}, '0, '0)));
        directed.push_back(make_row(make_item(CMD_PLAY, '0, '0, 8'd250, 8'd255)));
        directed.push_back(make_row(make_item(CMD_PLAY, '0, '0, 8'd0, 8'd254)));
        repeat (3)
            directed.push_back(make_row(make_item(CMD_TICK, '0, '0, '0, '0)));
        repeat (3)
            directed.push_back(make_row(make_item(CMD_TICK, '0, '0, '0, '0)));
        directed.push_back(make_row(make_item(CMD_PLAY, '0, '0, 8'd253, 8'd255)));
        directed.push_back(make_row(make_item(CMD_PLAY, '0, '0, 8'd254, 8'd255)));
        directed.push_back(make_row(make_item(CMD_TICK, '0, '0, '0, '0)));
        directed.push_back(make_row(make_item(CMD_PLAY, '0, '0, 8'd255, 8'd0)));
        directed.push_back(make_row(make_item(CMD_PLAY, '0, '0, 8'd0, 8'd1)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            offer(directed[k].item);
            predicted = advance_sequencer(directed[k].item);
            due_results.push_back(directed[k].typed ? directed[k].result : predicted);
        end

        quiesce();
        set_tuning(VOL_FIXED, 16'hFFFF);
        for (int a = 0; a < MEM_WORDS; a++)
            issue(make_item(CMD_LOAD, BYTE_W'(a), compose_note_word(), BYTE_W'($urandom),
                            BYTE_W'($urandom)));
        random_chunk(CHUNK_ITEMS);

        quiesce();
        set_tuning(VOL_EIGHTH, 16'h0000);
        steady <= 1'b1;
        random_chunk(STEADY_ITEMS);
        steady <= 1'b0;
        random_chunk(CHUNK_ITEMS - STEADY_ITEMS);

        quiesce();
        set_tuning(VOL_QUARTER, HALF_W'($urandom_range(2, 65534)));
        random_chunk(20);
        holdoff_go <= 1'b1;
        random_chunk(CHUNK_ITEMS - 20);

        quiesce();
        set_tuning(VOL_HALF, PAUSE_RESET);
        random_chunk(CHUNK_ITEMS);

        quiesce();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !holdoff_active && (steady || $urandom_range(0, 99) >= 33);
        end
    end

    initial
    begin
        wait (holdoff_go);
        @(posedge clk);
        holdoff_active <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_active <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: result transaction with nothing expected", $realtime);
                fail_count++;
            end
            else
            begin
                got_want = due_results.pop_front();
                check_field("timer_enable", 32'(got_want.timer_enable),
                            32'(rsp_ch.timer_enable));
                check_field("period", 32'(got_want.period), 32'(rsp_ch.period));
                check_field("compare", 32'(got_want.compare), 32'(rsp_ch.compare));
                check_field("counter_restart", 32'(got_want.counter_restart),
                            32'(rsp_ch.counter_restart));
                check_field("pin_forced_low", 32'(got_want.pin_forced_low),
                            32'(rsp_ch.pin_forced_low));
                check_field("note_active", 32'(got_want.note_active),
                            32'(rsp_ch.note_active));
                check_field("current_priority", 32'(got_want.current_priority),
                            32'(rsp_ch.current_priority));
                check_field("note_index", 32'(got_want.note_index), 32'(rsp_ch.note_index));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $realtime, due_results.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule
